// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the validator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/jsv_pkg.sv =====
`default_nettype none
package jsv_pkg;
    localparam logic [1:0] V_OK     = 2'd0;
    localparam logic [1:0] V_ACCEPT = 2'd1;
    localparam logic [1:0] V_REJECT = 2'd2;

    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_SYNTAX     = 3'd1;
    localparam logic [2:0] E_DEEP       = 3'd2;
    localparam logic [2:0] E_MANY       = 3'd3;
    localparam logic [2:0] E_LONG       = 3'd4;
    localparam logic [2:0] E_INCOMPLETE = 3'd5;

    localparam logic [1:0] CFG_MAX_DEPTH = 2'd0;
    localparam logic [1:0] CFG_MAX_NODES = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

    localparam logic [4:0] M_VALUE          = 5'd0;
    localparam logic [4:0] M_VALUE_OR_CLOSE = 5'd1;
    localparam logic [4:0] M_KEY_OR_CLOSE   = 5'd2;
    localparam logic [4:0] M_KEY            = 5'd3;
    localparam logic [4:0] M_COLON          = 5'd4;
    localparam logic [4:0] M_AFTER          = 5'd5;
    localparam logic [4:0] M_KSTR           = 5'd6;
    localparam logic [4:0] M_KESC           = 5'd7;
    localparam logic [4:0] M_KHEX           = 5'd8;
    localparam logic [4:0] M_VSTR           = 5'd9;
    localparam logic [4:0] M_VESC           = 5'd10;
    localparam logic [4:0] M_VHEX           = 5'd11;
    localparam logic [4:0] M_LIT            = 5'd12;
    localparam logic [4:0] M_N_SIGN         = 5'd13;
    localparam logic [4:0] M_N_ZERO         = 5'd14;
    localparam logic [4:0] M_N_INT          = 5'd15;
    localparam logic [4:0] M_N_DOT          = 5'd16;
    localparam logic [4:0] M_N_FRAC         = 5'd17;
    localparam logic [4:0] M_N_EXP          = 5'd18;
    localparam logic [4:0] M_N_EXPSIGN      = 5'd19;
    localparam logic [4:0] M_N_EXPDIG       = 5'd20;

    localparam logic [24:0] COUNT_MAX = 25'h1FFFFFF;

    // byte class computed by the front end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ws;
        logic       digit;
        logic       hex;
        logic       esc;
        logic       over_len;
    } t_req;

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (kind)
            2'd0: unique case (pos)
                3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                default: c = 8'h00;
            endcase
            2'd1: unique case (pos)
                3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
                default: c = 8'h00;
            endcase
            2'd2: unique case (pos)
                3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                default: c = 8'h00;
            endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        return (kind == 2'd1) ? 3'd5 : 3'd4;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/jsv_front.sv =====
`default_nettype none
// Accepts bytes, counts length, classifies the byte.
module jsv_front
    import jsv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic [24:0] i_max_bytes,
    output logic             o_valid,
    output t_req             o_req,
    input  wire logic        i_stall
);
    logic [24:0] r_count;
    logic [24:0] n_count;
    logic        r_valid;
    t_req        r_req;
    logic        take;
    logic [7:0]  c;

    assign c       = i_data_byte;
    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_comb begin
        n_count = (r_count != COUNT_MAX) ? r_count + 25'd1 : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_count <= i_last_byte ? '0 : n_count;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req.data     <= c;
            r_req.last     <= i_last_byte;
            r_req.ws       <= (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
            r_req.digit    <= (c >= "0") && (c <= "9");
            r_req.hex      <= ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "f"))
                           || ((c >= "A") && (c <= "F"));
            r_req.esc      <= (c == 8'h22) || (c == 8'h5C) || (c == "/") || (c == "b")
                           || (c == "f") || (c == "n") || (c == "r") || (c == "t");
            r_req.over_len <= n_count > i_max_bytes;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/jsv_back.sv =====
`default_nettype none
// Grammar state machine with container stack and output register.
module jsv_back
    import jsv_pkg::*;
#(
    parameter int STACK_ENTRIES = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_req       i_req,
    output logic            o_stall,
    input  wire logic [7:0] i_max_depth,
    input  wire logic [17:0] i_max_nodes,
    output logic            o_valid,
    output logic [1:0]      o_verdict,
    output logic [2:0]      o_error_kind,
    output logic            o_document_end,
    input  wire logic       i_stall
);
    localparam int SW = $clog2(STACK_ENTRIES);
    localparam int LW = $clog2(STACK_ENTRIES + 1) > 9 ? $clog2(STACK_ENTRIES + 1) : 9;
    localparam logic [LW-1:0] LVL_FULL = LW'(STACK_ENTRIES);

    logic              r_stack [STACK_ENTRIES];
    logic [4:0]        r_mode,  n_mode;
    logic [LW-1:0]     r_level, n_level;
    logic [18:0]       r_count, n_count;
    logic [2:0]        r_sub,   n_sub;
    logic [1:0]        r_kind,  n_kind;
    logic [2:0]        r_err,   n_err;
    logic              push;
    logic              push_obj;
    logic [SW-1:0]     push_idx;
    logic              r_top;     // copy of stack top entry
    logic              n_top;
    logic              r_below;   // entry below top, kept via stack read
    logic              r_ovalid;
    logic              take;
    logic [1:0]        verdict;
    logic              done;
    logic [2:0]        fin_err;

    assign o_stall = r_ovalid && i_stall;
    assign take    = i_valid && !o_stall;

    function automatic logic [2:0] begin_v(input logic [7:0] c, input logic [LW-1:0] lvl,
                                           input logic [18:0] cnt, input logic [7:0] md,
                                           input logic [17:0] mn);
        if (lvl > LW'(md)) return E_DEEP;
        if (cnt >= 19'(mn)) return E_MANY;
        if ((c == "{" || c == "[") && lvl >= LVL_FULL) return E_DEEP;
        if (c == 8'h22 || c == "{" || c == "[" || c == "t" || c == "f" || c == "n"
            || c == "-" || (c >= "0" && c <= "9")) return E_NONE;
        return E_SYNTAX;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [4:0] m;
        logic       redo;
        logic       bv;
        logic       cl;
        logic [2:0] e;
        c = i_req.data;
        m = r_mode;
        n_mode = r_mode; n_level = r_level; n_count = r_count; n_sub = r_sub;
        n_kind = r_kind; n_top = r_top;
        push = 1'b0; push_obj = (c == "{");
        e = E_NONE; bv = 1'b0; cl = 1'b0;
        // numbers end by handing the byte to the after-value state
        redo = ((m == M_N_ZERO) && c != "." && c != "e" && c != "E")
            || ((m == M_N_INT) && !i_req.digit && c != "." && c != "e" && c != "E")
            || ((m == M_N_FRAC) && !i_req.digit && c != "e" && c != "E")
            || ((m == M_N_EXPDIG) && !i_req.digit);
        if (redo) m = M_AFTER;
        if (i_req.ws && (m <= M_AFTER)) begin
            e = E_NONE;
            if (redo) n_mode = M_AFTER;
        end else begin
            unique case (m)
                M_VALUE: bv = 1'b1;
                M_VALUE_OR_CLOSE: begin
                    if (c == "]") cl = 1'b1; else bv = 1'b1;
                end
                M_KEY_OR_CLOSE: begin
                    if (c == "}") cl = 1'b1;
                    else if (c == 8'h22) n_mode = M_KSTR;
                    else e = E_SYNTAX;
                end
                M_KEY: begin
                    if (c == 8'h22) n_mode = M_KSTR; else e = E_SYNTAX;
                end
                M_COLON: begin
                    if (c == ":") n_mode = M_VALUE; else e = E_SYNTAX;
                end
                M_AFTER: begin
                    if (r_level == '0 || r_level > LVL_FULL) e = E_SYNTAX;
                    else if (c == ",") n_mode = r_top ? M_KEY : M_VALUE;
                    else if (c == "}" || c == "]") cl = 1'b1;
                    else e = E_SYNTAX;
                end
                M_KSTR, M_VSTR: begin
                    if (c == 8'h22) n_mode = (m == M_KSTR) ? M_COLON : M_AFTER;
                    else if (c < 8'h20) e = E_SYNTAX;
                    else if (c == 8'h5C) n_mode = m + 5'd1;
                end
                M_KESC, M_VESC: begin
                    if (c == "u") begin n_sub = '0; n_mode = m + 5'd1; end
                    else if (i_req.esc) n_mode = m - 5'd1;
                    else e = E_SYNTAX;
                end
                M_KHEX, M_VHEX: begin
                    if (!i_req.hex) e = E_SYNTAX;
                    else if (r_sub >= 3'd3) begin n_sub = '0; n_mode = m - 5'd2; end
                    else n_sub = r_sub + 3'd1;
                end
                M_LIT: begin
                    if (r_kind > 2'd2 || r_sub >= lit_len(r_kind)) e = E_SYNTAX;
                    else if (c != lit_char(r_kind, r_sub)) e = E_SYNTAX;
                    else if (r_sub + 3'd1 == lit_len(r_kind)) begin
                        n_sub = '0; n_mode = M_AFTER;
                    end else n_sub = r_sub + 3'd1;
                end
                M_N_SIGN: begin
                    if (c == "0") n_mode = M_N_ZERO;
                    else if (i_req.digit) n_mode = M_N_INT;
                    else e = E_SYNTAX;
                end
                M_N_ZERO, M_N_INT: begin
                    // a digit in the integer part keeps the mode
                    if (c == ".") n_mode = M_N_DOT;
                    else if (c == "e" || c == "E") n_mode = M_N_EXP;
                end
                M_N_DOT: begin
                    if (i_req.digit) n_mode = M_N_FRAC; else e = E_SYNTAX;
                end
                M_N_FRAC: begin
                    if (!i_req.digit) n_mode = M_N_EXP;
                end
                M_N_EXP: begin
                    if (c == "+" || c == "-") n_mode = M_N_EXPSIGN;
                    else if (i_req.digit) n_mode = M_N_EXPDIG;
                    else e = E_SYNTAX;
                end
                M_N_EXPSIGN: begin
                    if (i_req.digit) n_mode = M_N_EXPDIG; else e = E_SYNTAX;
                end
                M_N_EXPDIG: n_mode = M_N_EXPDIG;
                default: e = E_SYNTAX;
            endcase
        end
        if (bv) begin
            e = begin_v(c, r_level, r_count, i_max_depth, i_max_nodes);
            if (r_level <= LW'(i_max_depth) && r_count < 19'(i_max_nodes))
                n_count = r_count + 19'd1;
            if (e == E_NONE) begin
                if (c == 8'h22) n_mode = M_VSTR;
                else if (c == "{" || c == "[") begin
                    push = 1'b1; n_level = r_level + LW'(1); n_top = push_obj;
                    n_mode = push_obj ? M_KEY_OR_CLOSE : M_VALUE_OR_CLOSE;
                end else if (c == "t" || c == "f" || c == "n") begin
                    n_kind = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
                    n_sub = 3'd1; n_mode = M_LIT;
                end else if (c == "-") n_mode = M_N_SIGN;
                else if (c == "0") n_mode = M_N_ZERO;
                else n_mode = M_N_INT;
            end
        end
        if (cl) begin
            if (r_level == '0 || r_level > LVL_FULL) e = E_SYNTAX;
            else if (c != (r_top ? "}" : "]")) e = E_SYNTAX;
            else begin
                n_level = r_level - LW'(1); n_mode = M_AFTER; n_top = r_below;
            end
        end
        if (r_err != E_NONE) n_err = r_err;
        else if (i_req.over_len) n_err = E_LONG;
        else n_err = e;
        done = (n_level == '0) && (n_mode == M_AFTER || n_mode == M_N_ZERO
            || n_mode == M_N_INT || n_mode == M_N_FRAC || n_mode == M_N_EXPDIG);
        fin_err = (n_err == E_NONE && !done) ? E_INCOMPLETE : n_err;
        if (i_req.last) verdict = (fin_err == E_NONE) ? V_ACCEPT : V_REJECT;
        else verdict = (n_err == E_NONE) ? V_OK : V_REJECT;
    end

    // a taken byte commits its state update only with no earlier error and within the length limit
    logic commit;
    assign commit = take && (r_err == E_NONE) && !i_req.over_len;
    assign push_idx = r_level[SW-1:0];

    // level held after this edge; the entry below its top is read for it
    logic [LW-1:0] lvl_nx;
    assign lvl_nx = (take && i_req.last) ? '0 : (commit ? n_level : r_level);

    logic [LW-1:0] rd_lvl;
    assign rd_lvl = (lvl_nx >= LW'(2)) ? lvl_nx - LW'(2) : '0;

    always_ff @(posedge i_clk) begin
        if (commit && push && n_err == E_NONE) r_stack[push_idx] <= push_obj;
        r_below <= (commit && push && n_err == E_NONE && n_level >= LW'(2)
                    && rd_lvl == r_level - LW'(1)) ? r_top : r_stack[rd_lvl[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_VALUE; r_level <= '0; r_count <= '0; r_sub <= '0;
            r_kind <= '0; r_err <= E_NONE; r_ovalid <= 1'b0; r_top <= 1'b0;
        end else begin
            if (take) begin
                r_ovalid <= 1'b1;
                if (i_req.last) begin
                    r_mode <= M_VALUE; r_level <= '0; r_count <= '0; r_sub <= '0;
                    r_kind <= '0; r_err <= E_NONE;
                end else begin
                    r_err <= n_err;
                    if (commit) begin
                        r_mode <= n_mode; r_level <= n_level; r_count <= n_count;
                        r_sub <= n_sub; r_kind <= n_kind; r_top <= n_top;
                    end
                end
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_verdict      <= verdict;
            o_error_kind   <= i_req.last ? fin_err : n_err;
            o_document_end <= i_req.last;
        end
    end
    assign o_valid = r_ovalid;
endmodule
`default_nettype wire

// ===== rtl/core/jsv_queue.sv =====
`default_nettype none
// Two-entry request queue between front and back.
module jsv_queue
    import jsv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_req i_req,
    output logic      o_stall,
    output logic      o_valid,
    output t_req      o_req,
    input  wire logic i_stall
);
    t_req r_q [2];
    logic r_rd, r_wr;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rd];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0; r_wr <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/json_syntax_validator.sv =====
`default_nettype none
// Streaming strict-JSON syntax checker: one byte per clock sustained while
// nothing stalls, one request per byte, one result per request. A request
// passes the front register, a queue entry and the output register, in that
// order. The front end counts length and classifies bytes; the back end runs
// the grammar state machine, a container stack of STACK_ENTRIES one-bit
// entries (a memory read one level below the top each cycle) and limit
// checks. The first error is kept until the byte flagged last, whose result
// carries the final verdict and clears the document state. The user must
// write configuration only while idle; the block does not enforce this.
module json_syntax_validator
    import jsv_pkg::*;
#(
    parameter int STACK_ENTRIES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_verdict,
    output logic [2:0]       o_error_kind,
    output logic             o_document_end,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [24:0] i_cfg_data
);
    logic [7:0]  r_max_depth;
    logic [17:0] r_max_nodes;
    logic [24:0] r_max_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth <= 8'd128;
            r_max_nodes <= 18'd200000;
            r_max_bytes <= 25'd8388608;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_DEPTH: r_max_depth <= i_cfg_data[7:0];
                CFG_MAX_NODES: r_max_nodes <= i_cfg_data[17:0];
                CFG_MAX_BYTES: r_max_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic f_valid, f_stall, q_valid, q_stall;
    t_req f_req, q_req;

    jsv_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_data_byte, .i_last_byte, .i_max_bytes(r_max_bytes),
        .o_valid(f_valid), .o_req(f_req), .i_stall(f_stall)
    );

    jsv_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_req(f_req), .o_stall(f_stall),
        .o_valid(q_valid), .o_req(q_req), .i_stall(q_stall)
    );

    jsv_back #(.STACK_ENTRIES(STACK_ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_req(q_req), .o_stall(q_stall),
        .i_max_depth(r_max_depth), .i_max_nodes(r_max_nodes),
        .o_valid, .o_verdict, .o_error_kind, .o_document_end, .i_stall
    );
endmodule
`default_nettype wire

// ===== rtl/core/jsv_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module jsv_checker
    import jsv_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_verdict,
    input wire logic [2:0] o_error_kind,
    input wire logic       o_document_end
);
    `CHK_IMPL(a_kind_zero, i_clk, i_rst_n,
        o_valid && o_verdict != V_REJECT, o_error_kind == E_NONE, "kind set without reject")
    `CHK_IMPL(a_reject_kind, i_clk, i_rst_n,
        o_valid && o_verdict == V_REJECT, o_error_kind != E_NONE, "reject without kind")
    `CHK_IMPL(a_accept_end, i_clk, i_rst_n,
        o_valid && o_verdict == V_ACCEPT, o_document_end, "accept before end")
    `CHK_NEXT(a_hold, i_clk, i_rst_n,
        o_valid && i_stall, o_valid && $stable(o_verdict), "stalled result moved")
endmodule
bind json_syntax_validator jsv_checker u_chk (.*);
`default_nettype wire

// ===== tb/json_syntax_validator_tb.sv =====
`timescale 1ns / 1ps

module json_syntax_validator_tb;
    import jsv_pkg::*;

    localparam int NUM_BYTES  = 1750;  // byte total, directed bytes included, that ends the random phases
    localparam int STALL_PCT  = 28;
    localparam int HANG_LIMIT = 5000;  // cycles with no handshake at all
    localparam int DRAIN_WAIT = 8;     // front reg + queue + output reg, with margin

    typedef struct {
        logic [1:0] verdict;
        logic [2:0] kind;
        logic       doc_end;
    } t_verdict;

    // ------------------------------------------------------------------
    // Scoreboard: shadow parser of the grammar plus the queue of verdicts
    // still owed by the block.
    // ------------------------------------------------------------------
    class t_doc_scoreboard;
        bit [7:0]    lim_depth;
        bit [17:0]   lim_nodes;
        bit [24:0]   lim_bytes;
        logic [4:0]  mode;
        int          level;
        int unsigned nvalues;
        bit [24:0]   nbytes;
        int          sub;
        int          lkind;
        logic [2:0]  err;
        bit          open_kind[256];   // 1 = object, 0 = array
        t_verdict    owed[$];
        int          mismatches;
        int          checked;
        int          docs_ok;
        int          docs_bad;
        string       lits[3];

        function new();
            lits = '{"true", "false", "null"};
            lim_depth = 8'd128;
            lim_nodes = 18'd200000;
            lim_bytes = 25'd8388608;
            clear_doc();
        endfunction

        function void clear_doc();
            mode = M_VALUE;
            level = 0;
            nvalues = 0;
            nbytes = '0;
            sub = 0;
            lkind = 0;
            err = E_NONE;
        endfunction

        function void set_limit(logic [1:0] idx, logic [24:0] val);
            case (idx)
                CFG_MAX_DEPTH: lim_depth = val[7:0];
                CFG_MAX_NODES: lim_nodes = val[17:0];
                CFG_MAX_BYTES: lim_bytes = val;
                default: ;
            endcase
        endfunction

        function bit is_ws(bit [7:0] c);
            return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
        endfunction

        function bit is_dig(bit [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_hexc(bit [7:0] c);
            return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function logic [2:0] open_value(bit [7:0] c);
            // depth limit, then value count, then the byte itself
            if (level > lim_depth) return E_DEEP;
            if (nvalues >= lim_nodes) return E_MANY;
            nvalues++;
            if (c == "\"") begin
                mode = M_VSTR;
                return E_NONE;
            end
            if (c == "{" || c == "[") begin
                if (level >= 256) return E_DEEP;
                open_kind[level] = (c == "{");
                level++;
                mode = (c == "{") ? M_KEY_OR_CLOSE : M_VALUE_OR_CLOSE;
                return E_NONE;
            end
            if (c == "t" || c == "f" || c == "n") begin
                lkind = (c == "t") ? 0 : (c == "f") ? 1 : 2;
                sub = 1;
                mode = M_LIT;
                return E_NONE;
            end
            if (c == "-") begin
                mode = M_N_SIGN;
                return E_NONE;
            end
            if (c == "0") begin
                mode = M_N_ZERO;
                return E_NONE;
            end
            if (c >= "1" && c <= "9") begin
                mode = M_N_INT;
                return E_NONE;
            end
            return E_SYNTAX;
        endfunction

        function logic [2:0] close_one(bit [7:0] c);
            bit [7:0] want;
            if (level == 0) return E_SYNTAX;
            want = open_kind[level-1] ? "}" : "]";
            if (c != want) return E_SYNTAX;
            level--;
            mode = M_AFTER;
            return E_NONE;
        endfunction

        function logic [2:0] in_string(bit [7:0] c, bit key);
            logic [4:0] base;
            logic [4:0] part;
            base = key ? M_KSTR : M_VSTR;
            part = mode - base;
            if (part == 0) begin
                if (c == "\"") begin
                    mode = key ? M_COLON : M_AFTER;
                    return E_NONE;
                end
                if (c < 8'h20) return E_SYNTAX;
                if (c == "\\") mode = base + 5'd1;
                return E_NONE;
            end
            if (part == 1) begin
                if (c == "u") begin
                    sub = 0;
                    mode = base + 5'd2;
                    return E_NONE;
                end
                if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                    c == "n" || c == "r" || c == "t") begin
                    mode = base;
                    return E_NONE;
                end
                return E_SYNTAX;
            end
            if (!is_hexc(c)) return E_SYNTAX;
            sub++;
            if (sub >= 4) begin
                sub = 0;
                mode = base;
            end
            return E_NONE;
        endfunction

        function logic [2:0] parse(bit [7:0] c);
            bit ws;
            ws = is_ws(c);
            case (mode)
                M_VALUE: return ws ? E_NONE : open_value(c);
                M_VALUE_OR_CLOSE: begin
                    if (ws) return E_NONE;
                    return (c == "]") ? close_one(c) : open_value(c);
                end
                M_KEY_OR_CLOSE: begin
                    if (ws) return E_NONE;
                    if (c == "}") return close_one(c);
                    if (c == "\"") begin
                        mode = M_KSTR;
                        return E_NONE;
                    end
                    return E_SYNTAX;
                end
                M_KEY: begin
                    if (ws) return E_NONE;
                    if (c == "\"") begin
                        mode = M_KSTR;
                        return E_NONE;
                    end
                    return E_SYNTAX;
                end
                M_COLON: begin
                    if (ws) return E_NONE;
                    if (c == ":") begin
                        mode = M_VALUE;
                        return E_NONE;
                    end
                    return E_SYNTAX;
                end
                M_AFTER: begin
                    if (ws) return E_NONE;
                    if (level == 0) return E_SYNTAX;
                    if (c == ",") begin
                        mode = open_kind[level-1] ? M_KEY : M_VALUE;
                        return E_NONE;
                    end
                    if (c == "}" || c == "]") return close_one(c);
                    return E_SYNTAX;
                end
                M_KSTR, M_KESC, M_KHEX: return in_string(c, 1'b1);
                M_VSTR, M_VESC, M_VHEX: return in_string(c, 1'b0);
                M_LIT: begin
                    if (sub >= lits[lkind].len()) return E_SYNTAX;
                    if (c != lits[lkind][sub]) return E_SYNTAX;
                    sub++;
                    if (sub == lits[lkind].len()) begin
                        sub = 0;
                        mode = M_AFTER;
                    end
                    return E_NONE;
                end
                M_N_SIGN: begin
                    if (c == "0") begin
                        mode = M_N_ZERO;
                        return E_NONE;
                    end
                    if (c >= "1" && c <= "9") begin
                        mode = M_N_INT;
                        return E_NONE;
                    end
                    return E_SYNTAX;
                end
                M_N_ZERO, M_N_INT: begin
                    if (mode == M_N_INT && is_dig(c)) return E_NONE;
                    if (c == ".") begin
                        mode = M_N_DOT;
                        return E_NONE;
                    end
                    if (c == "e" || c == "E") begin
                        mode = M_N_EXP;
                        return E_NONE;
                    end
                    // number ends here; the byte belongs to what follows
                    mode = M_AFTER;
                    return parse(c);
                end
                M_N_DOT: begin
                    if (is_dig(c)) begin
                        mode = M_N_FRAC;
                        return E_NONE;
                    end
                    return E_SYNTAX;
                end
                M_N_FRAC: begin
                    if (is_dig(c)) return E_NONE;
                    if (c == "e" || c == "E") begin
                        mode = M_N_EXP;
                        return E_NONE;
                    end
                    mode = M_AFTER;
                    return parse(c);
                end
                M_N_EXP: begin
                    if (c == "+" || c == "-") begin
                        mode = M_N_EXPSIGN;
                        return E_NONE;
                    end
                    if (is_dig(c)) begin
                        mode = M_N_EXPDIG;
                        return E_NONE;
                    end
                    return E_SYNTAX;
                end
                M_N_EXPSIGN: begin
                    if (is_dig(c)) begin
                        mode = M_N_EXPDIG;
                        return E_NONE;
                    end
                    return E_SYNTAX;
                end
                M_N_EXPDIG: begin
                    if (is_dig(c)) return E_NONE;
                    mode = M_AFTER;
                    return parse(c);
                end
                default: return E_SYNTAX;
            endcase
        endfunction

        // accepted request: advance the shadow parser, queue the verdict
        function void note_byte(bit [7:0] c, bit last);
            t_verdict v;
            bit done;
            if (nbytes != COUNT_MAX) nbytes++;
            if (err == E_NONE) begin
                // length limit wins over syntax
                if (nbytes > lim_bytes) err = E_LONG;
                else err = parse(c);
            end
            v.kind = err;
            v.doc_end = last;
            if (last) begin
                done = level == 0 && (mode == M_AFTER || mode == M_N_ZERO ||
                    mode == M_N_INT || mode == M_N_FRAC || mode == M_N_EXPDIG);
                if (err == E_NONE && !done) err = E_INCOMPLETE;
                v.kind = err;
                v.verdict = (err == E_NONE) ? V_ACCEPT : V_REJECT;
                if (err == E_NONE) docs_ok++;
                else docs_bad++;
                clear_doc();
            end else begin
                v.verdict = (err == E_NONE) ? V_OK : V_REJECT;
            end
            owed.insert(owed.size(), v);
        endfunction

        function void check_result(logic [1:0] verdict, logic [2:0] kind, logic doc_end);
            t_verdict v;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: verdict=%0d kind=%0d end=%0d",
                             $realtime, verdict, kind, doc_end);
                return;
            end
            v = owed.pop_front();
            checked++;
            if (verdict !== v.verdict || kind !== v.kind || doc_end !== v.doc_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result %0d: expected v=%0d k=%0d e=%0d, got v=%0d k=%0d e=%0d",
                             $realtime, checked, v.verdict, v.kind, v.doc_end,
                             verdict, kind, doc_end);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_verdict;
    logic [2:0]  o_error_kind;
    logic        o_document_end;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [24:0] i_cfg_data = '0;

    t_doc_scoreboard sb = new();
    bit [7:0]      doc[$];           // document being assembled
    bit            no_idle = 1'b0;   // stretch with steady traffic on both sides
    int            bytes_sent = 0;
    int            docs_sent = 0;
    int            quiet_cycles = 0;

    json_syntax_validator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_verdict      (o_verdict),
        .o_error_kind   (o_error_kind),
        .o_document_end (o_document_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Monitors run on pre-edge values, so they see exactly what the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_byte(i_data_byte, i_last_byte);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_verdict, o_error_kind, o_document_end);
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < STALL_PCT);
        end
    end

    // Hang detector: any cycle without a handshake on either side counts.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // append one byte to the document being assembled
    function automatic void add_byte(bit [7:0] c);
        doc.insert(doc.size(), c);
    endfunction

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    task automatic push_byte(bit [7:0] c, bit last);
        if (!no_idle) begin
            while ($urandom_range(99) < STALL_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_data_byte <= c;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_doc();
        foreach (doc[i]) push_byte(doc[i], i == doc.size() - 1);
        docs_sent++;
        doc.delete();
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
        send_doc();
    endtask

    // Limits change only with nothing in flight.
    task automatic write_limit(logic [1:0] idx, logic [24:0] val);
        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(idx, val);
    endtask

    // ------------------------------------------------------------------
    // Random document builder
    // ------------------------------------------------------------------
    function automatic void put(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void pad();
        string sp;
        sp = " \t\r\n";
        while ($urandom_range(99) < 25) add_byte(sp[$urandom_range(0, 3)]);
    endfunction

    function automatic void make_string();
        string esc;
        string hexd;
        bit [7:0] c;
        esc = "\"\\/bfnrt";
        hexd = "0123456789abcdefABCDEF";
        put("\"");
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 9))
                0: begin
                    put("\\");
                    add_byte(esc[$urandom_range(0, 7)]);
                end
                1: begin
                    put("\\u");
                    repeat (4) add_byte(hexd[$urandom_range(0, 21)]);
                end
                default: begin
                    do c = $urandom_range(8'h20, 8'hFF); while (c == "\"" || c == "\\");
                    add_byte(c);
                end
            endcase
        end
        put("\"");
    endfunction

    function automatic void make_number();
        if ($urandom_range(0, 2) == 0) put("-");
        if ($urandom_range(0, 3) == 0) begin
            put("0");
        end else begin
            add_byte(8'($urandom_range("1", "9")));
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 2) == 0) begin
            put(".");
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 3) == 0) begin
            put($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0: put("+");
                1: put("-");
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range("0", "9")));
        end
    endfunction

    function automatic void make_value(int lvl);
        int pick;
        int n;
        pick = (lvl >= 5) ? $urandom_range(2, 7) : $urandom_range(0, 7);
        case (pick)
            0: begin
                put("{");
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i != 0) put(",");
                    pad();
                    make_string();
                    pad();
                    put(":");
                    pad();
                    make_value(lvl + 1);
                    pad();
                end
                put("}");
            end
            1: begin
                put("[");
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i != 0) put(",");
                    pad();
                    make_value(lvl + 1);
                    pad();
                end
                put("]");
            end
            2, 3: make_string();
            4, 5: make_number();
            6: put($urandom_range(0, 1) ? "true" : "null");
            default: put("false");
        endcase
    endfunction

    // Mostly well-formed documents; some get corrupted or are pure noise.
    function automatic void make_doc();
        int r;
        int n;
        pad();
        make_value(0);
        pad();
        r = $urandom_range(0, 99);
        if (r < 12) begin
            doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r < 17) begin
            n = $urandom_range(1, doc.size());
            while (doc.size() > n) void'(doc.pop_back());
        end else if (r < 21) begin
            doc.delete();
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
        end else if (r < 25) begin
            doc.insert($urandom_range(0, doc.size()), 8'($urandom_range(0, 255)));
        end
    endfunction

    // Random limits: mostly roomy, sometimes tight, sometimes at the extremes.
    task automatic pick_limits();
        case ($urandom_range(0, 5))
            0: write_limit(CFG_MAX_DEPTH, 25'($urandom_range(0, 3)));
            1: write_limit(CFG_MAX_DEPTH, 25'd255);
            default: write_limit(CFG_MAX_DEPTH, 25'($urandom_range(4, 254)));
        endcase
        case ($urandom_range(0, 5))
            0: write_limit(CFG_MAX_NODES, 25'($urandom_range(0, 12)));
            1: write_limit(CFG_MAX_NODES, 25'h3FFFF);
            default: write_limit(CFG_MAX_NODES, 25'($urandom_range(13, 262142)));
        endcase
        case ($urandom_range(0, 5))
            0: write_limit(CFG_MAX_BYTES, 25'($urandom_range(0, 40)));
            1: write_limit(CFG_MAX_BYTES, 25'h1FFFFFF);
            2: write_limit(CFG_MAX_BYTES, 25'd16777216);
            default: write_limit(CFG_MAX_BYTES, 25'($urandom_range(41, 25'h1FFFFFE)));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // grammar corners under reset limits
        send_text("true");
        send_text("false");
        send_text("null");
        send_text(" -0.5e+3 ");
        send_text("0");
        send_text("{\"a\":[1,2.5E-1,{}],\"b\":\"x\\u00aF\\n\\/\"}");
        send_text("[tru]");
        send_text("\"\\q\"");
        send_text("01");
        send_text("[1,2");
        send_text("{\"k\" 1}");
        send_text(" \t\r\n");
        send_text("\"\\u12g4\"");
        send_text("12e");
        send_text("[123,45]");
        doc = '{8'h22, 8'h01, 8'h22};   // raw control byte in a string
        send_doc();
        doc = '{8'h22, 8'hFF, 8'h80, 8'h22};
        send_doc();

        // depth limit: zero, then deepest nesting the stack allows
        write_limit(CFG_MAX_DEPTH, 25'd0);
        send_text("[1]");
        send_text("7");
        write_limit(CFG_MAX_DEPTH, 25'd255);
        // long stretch with steady traffic on both sides
        no_idle = 1'b1;
        repeat (257) add_byte("[");
        repeat (257) add_byte("]");
        send_doc();
        repeat (256) add_byte("[");
        repeat (256) add_byte("]");
        send_doc();
        no_idle = 1'b0;

        // value count limit
        write_limit(CFG_MAX_NODES, 25'd0);
        send_text("1");
        write_limit(CFG_MAX_NODES, 25'd2);
        send_text("[1,2]");
        send_text("{\"a\":1}");

        // length limit, including zero, then a roomy byte limit and the widest value count limit
        write_limit(CFG_MAX_BYTES, 25'd0);
        send_text("1");
        write_limit(CFG_MAX_BYTES, 25'd1);
        send_text("12");
        send_text("5");
        write_limit(CFG_MAX_BYTES, 25'd16777216);
        write_limit(CFG_MAX_NODES, 25'h3FFFF);
        send_text("[true,{\"x\":null}]");

        // random phases; the second one runs with no idling on either side
        phase = 0;
        while (bytes_sent < NUM_BYTES) begin
            pick_limits();
            no_idle = (phase == 1);
            repeat (15) begin
                if (bytes_sent < NUM_BYTES) begin
                    make_doc();
                    send_doc();
                end
            end
            phase++;
        end
        no_idle = 1'b0;

        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d documents, %0d bytes, %0d results checked (%0d accepted, %0d rejected)",
                 docs_sent, bytes_sent, sb.checked, sb.docs_ok, sb.docs_bad);
        $display("covered limit extremes, corrupted and noise documents, idle and busy stretches");
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
